// ===== hdl/topological_sort_indegree_assert.svh =====
// Assertion macros used by the topological sort datapath.
`ifndef TOPOLOGICAL_SORT_INDEGREE_ASSERT_SVH
`define TOPOLOGICAL_SORT_INDEGREE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked property, disabled while reset is high.
`define TSI_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Checked property, evaluated during reset too.
`define TSI_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define TSI_ASSERT(label, clk, rst, prop)
`define TSI_ASSERT_NORST(label, clk, prop)
`endif

`endif

// ===== hdl/tsi_pkg.sv =====
// Shared types and codes for the topological sort block.
package tsi_pkg;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    ST_CLR_HEAD,
    ST_IDLE,
    ST_ADD,
    ST_DEG_CLR,
    ST_HEAD_RD,
    ST_HEAD_WAIT,
    ST_EDGE_CHK,
    ST_EDGE_DAT,
    ST_DEG_UPD,
    ST_PUSH_RD,
    ST_PUSH_CHK,
    ST_POP,
    ST_POP_TAKE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic head_clr;
    logic idx_clr;
    logic idx_inc;
    logic add_chk;
    logic add_wr;
    logic graph_clr;
    logic run_init;
    logic deg_clr;
    logic head_rd_idx;
    logic head_rd_stk;
    logic e_load;
    logic edge_rd;
    logic e_link;
    logic deg_rd_t;
    logic deg_rd_idx;
    logic deg_inc;
    logic deg_dec;
    logic push_chk;
    logic pop;
    logic pop_take;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic idx_lt_n;
    logic e_lt_count;
    logic t_lt_n;
    logic depth_nz;
    logic edge_ok;
  } stat_t;

endpackage

// ===== hdl/tsi_ctrl.sv =====
// Sequencer for edge loads, graph clears and the sort run.
module tsi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        kind,
  output logic              busy,
  output tsi_pkg::cmd_t     cmd,
  input  tsi_pkg::stat_t    stat
);

  tsi_pkg::state_t state, state_next;
  logic            walk_pop, walk_pop_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tsi_pkg::ST_CLR_HEAD;
      walk_pop <= 1'b0;
    end else begin
      state    <= state_next;
      walk_pop <= walk_pop_next;
    end
  end

  always_comb begin
    cmd           = '0;
    state_next    = state;
    walk_pop_next = walk_pop;
    unique case (state)
      tsi_pkg::ST_CLR_HEAD: begin
        cmd.head_clr = 1'b1;
        if (stat.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = tsi_pkg::ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      tsi_pkg::ST_IDLE: begin
        if (start) begin
          unique case (kind)
            tsi_pkg::KIND_ADD: begin
              cmd.add_chk = 1'b1;
              if (stat.edge_ok) state_next = tsi_pkg::ST_ADD;
            end
            tsi_pkg::KIND_RUN: begin
              cmd.run_init  = 1'b1;
              cmd.idx_clr   = 1'b1;
              walk_pop_next = 1'b0;
              state_next    = tsi_pkg::ST_DEG_CLR;
            end
            tsi_pkg::KIND_CLEAR: begin
              cmd.graph_clr = 1'b1;
              cmd.idx_clr   = 1'b1;
              state_next    = tsi_pkg::ST_CLR_HEAD;
            end
            default: ;
          endcase
        end
      end
      tsi_pkg::ST_ADD: begin
        cmd.add_wr = 1'b1;
        state_next = tsi_pkg::ST_IDLE;
      end
      tsi_pkg::ST_DEG_CLR: begin
        if (stat.idx_lt_n) begin
          cmd.deg_clr = 1'b1;
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = tsi_pkg::ST_HEAD_RD;
        end
      end
      tsi_pkg::ST_HEAD_RD: begin
        if (stat.idx_lt_n) begin
          cmd.head_rd_idx = 1'b1;
          state_next      = tsi_pkg::ST_HEAD_WAIT;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = tsi_pkg::ST_PUSH_RD;
        end
      end
      tsi_pkg::ST_HEAD_WAIT: begin
        cmd.e_load = 1'b1;
        state_next = tsi_pkg::ST_EDGE_CHK;
      end
      tsi_pkg::ST_EDGE_CHK: begin
        if (stat.e_lt_count) begin
          cmd.edge_rd = 1'b1;
          state_next  = tsi_pkg::ST_EDGE_DAT;
        end else if (walk_pop) begin
          state_next = tsi_pkg::ST_POP;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = tsi_pkg::ST_HEAD_RD;
        end
      end
      tsi_pkg::ST_EDGE_DAT: begin
        cmd.e_link = 1'b1;
        if (stat.t_lt_n) begin
          cmd.deg_rd_t = 1'b1;
          state_next   = tsi_pkg::ST_DEG_UPD;
        end else begin
          state_next = tsi_pkg::ST_EDGE_CHK;
        end
      end
      tsi_pkg::ST_DEG_UPD: begin
        if (walk_pop) cmd.deg_dec = 1'b1;
        else          cmd.deg_inc = 1'b1;
        state_next = tsi_pkg::ST_EDGE_CHK;
      end
      tsi_pkg::ST_PUSH_RD: begin
        if (stat.idx_lt_n) begin
          cmd.deg_rd_idx = 1'b1;
          state_next     = tsi_pkg::ST_PUSH_CHK;
        end else begin
          walk_pop_next = 1'b1;
          state_next    = tsi_pkg::ST_POP;
        end
      end
      tsi_pkg::ST_PUSH_CHK: begin
        cmd.push_chk = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = tsi_pkg::ST_PUSH_RD;
      end
      tsi_pkg::ST_POP: begin
        if (stat.depth_nz) begin
          cmd.pop    = 1'b1;
          state_next = tsi_pkg::ST_POP_TAKE;
        end else begin
          state_next = tsi_pkg::ST_DONE;
        end
      end
      tsi_pkg::ST_POP_TAKE: begin
        cmd.pop_take    = 1'b1;
        cmd.head_rd_stk = 1'b1;
        state_next      = tsi_pkg::ST_HEAD_WAIT;
      end
      tsi_pkg::ST_DONE: begin
        cmd.finish = 1'b1;
        state_next = tsi_pkg::ST_IDLE;
      end
      default: state_next = tsi_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state != tsi_pkg::ST_IDLE);

endmodule

// ===== hdl/tsi_datapath.sv =====
// Graph stores, in-degree store, ready stack and result registers.
`include "topological_sort_indegree_assert.svh"

module tsi_datapath #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  tsi_pkg::cmd_t     cmd,
  output tsi_pkg::stat_t    stat,
  input  logic [6:0]        from_node,
  input  logic [6:0]        to_node,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_data,
  output logic              result_strobe,
  output logic [6:0]        node,
  output logic              node_valid,
  output logic              last,
  output logic              complete,
  output logic              edges_dropped
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EW  = $clog2(MAX_EDGES);
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int RW  = (NCW > 7) ? NCW : 7;
  localparam logic [ECW-1:0] EMPTY = ECW'(MAX_EDGES);

  logic [ECW-1:0] list_head   [MAX_NODES];
  logic [NW-1:0]  edge_target [MAX_EDGES];
  logic [ECW-1:0] edge_link   [MAX_EDGES];
  logic [ECW-1:0] in_degree   [MAX_NODES];
  logic [NW-1:0]  ready_stack [MAX_NODES];

  logic [RW-1:0]  num_nodes;
  logic [NCW-1:0] n_act;
  logic [NCW-1:0] idx;
  logic [ECW-1:0] edge_count;
  logic           drop_flag;
  logic [NCW-1:0] depth;
  logic [NCW-1:0] emitted;
  logic           pend_valid;
  logic [6:0]     pend_node;
  logic [NW-1:0]  src_q;
  logic [NW-1:0]  dst_q;
  logic [ECW-1:0] e;

  logic [ECW-1:0] head_q;
  logic [NW-1:0]  t_q;
  logic [ECW-1:0] link_q;
  logic [ECW-1:0] deg_q;
  logic [NW-1:0]  stack_q;

  logic           edge_ok;
  logic [NW-1:0]  from_m1;
  logic [NW-1:0]  to_m1;
  logic           head_we, head_re;
  logic [NW-1:0]  head_wa, head_ra;
  logic [ECW-1:0] head_wd;
  logic           deg_we, deg_re, deg_dec_we;
  logic [NW-1:0]  deg_wa, deg_ra;
  logic [ECW-1:0] deg_wd;
  logic           push, push_dec, push_init;
  logic [NW-1:0]  push_data;
  logic [NCW-1:0] depth_m1;

  always_comb begin
    n_act   = (int'(num_nodes) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(num_nodes);
    from_m1 = NW'(from_node - 7'd1);
    to_m1   = NW'(to_node - 7'd1);
    edge_ok = (from_node != 7'd0) && (int'(from_node) <= int'(n_act)) &&
              (to_node != 7'd0) && (int'(to_node) <= int'(n_act)) &&
              (int'(edge_count) < MAX_EDGES);

    stat.idx_last   = (idx == NCW'(MAX_NODES - 1));
    stat.idx_lt_n   = (idx < n_act);
    stat.e_lt_count = (e < edge_count);
    stat.t_lt_n     = (int'(t_q) < int'(n_act));
    stat.depth_nz   = (depth != '0);
    stat.edge_ok    = edge_ok;

    head_we = cmd.head_clr | cmd.add_wr;
    head_wa = cmd.add_wr ? src_q : idx[NW-1:0];
    head_wd = cmd.add_wr ? edge_count : EMPTY;
    head_re = (cmd.add_chk & edge_ok) | cmd.head_rd_idx | cmd.head_rd_stk;
    priority if (cmd.add_chk)     head_ra = from_m1;
    else if (cmd.head_rd_stk)     head_ra = stack_q;
    else                          head_ra = idx[NW-1:0];

    // decrement only a nonzero count; the node becomes ready when it hits zero
    deg_dec_we = cmd.deg_dec && (deg_q != '0);
    push_dec   = cmd.deg_dec && (deg_q == ECW'(1));
    push_init  = cmd.push_chk && (deg_q == '0);
    push       = push_dec | push_init;
    push_data  = push_dec ? t_q : idx[NW-1:0];

    deg_we = cmd.deg_clr | cmd.deg_inc | deg_dec_we;
    deg_wa = cmd.deg_clr ? idx[NW-1:0] : t_q;
    priority if (cmd.deg_clr) deg_wd = '0;
    else if (cmd.deg_inc)     deg_wd = deg_q + ECW'(1);
    else                      deg_wd = deg_q - ECW'(1);
    deg_re = cmd.deg_rd_t | cmd.deg_rd_idx;
    deg_ra = cmd.deg_rd_t ? t_q : idx[NW-1:0];

    depth_m1 = depth - NCW'(1);
  end

  always_ff @(posedge clk) begin
    if (head_we) list_head[head_wa] <= head_wd;
    if (head_re) head_q <= list_head[head_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      edge_target[edge_count[EW-1:0]] <= dst_q;
      edge_link[edge_count[EW-1:0]]   <= head_q;
    end
    if (cmd.edge_rd) begin
      t_q    <= edge_target[e[EW-1:0]];
      link_q <= edge_link[e[EW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (deg_we) in_degree[deg_wa] <= deg_wd;
    if (deg_re) deg_q <= in_degree[deg_ra];
  end

  always_ff @(posedge clk) begin
    if (push) ready_stack[depth[NW-1:0]] <= push_data;
    if (cmd.pop) stack_q <= ready_stack[depth_m1[NW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_nodes     <= RW'(MAX_NODES);
      idx           <= '0;
      edge_count    <= '0;
      drop_flag     <= 1'b0;
      depth         <= '0;
      emitted       <= '0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      if (cfg_we) num_nodes <= RW'(cfg_data);

      priority if (cmd.idx_clr) idx <= '0;
      else if (cmd.idx_inc)     idx <= idx + NCW'(1);

      priority if (cmd.graph_clr) edge_count <= '0;
      else if (cmd.add_wr)        edge_count <= edge_count + ECW'(1);

      priority if (cmd.graph_clr)          drop_flag <= 1'b0;
      else if (cmd.add_chk && !edge_ok)    drop_flag <= 1'b1;

      priority if (cmd.run_init) depth <= '0;
      else if (cmd.pop)          depth <= depth_m1;
      else if (push)             depth <= depth + NCW'(1);

      priority if (cmd.run_init) emitted <= '0;
      else if (cmd.pop_take)     emitted <= emitted + NCW'(1);

      priority if (cmd.run_init || cmd.finish) pend_valid <= 1'b0;
      else if (cmd.pop_take)                   pend_valid <= 1'b1;

      result_strobe <= (cmd.pop && pend_valid) || cmd.finish;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.add_chk) begin
      src_q <= from_m1;
      dst_q <= to_m1;
    end
    priority if (cmd.e_load) e <= head_q;
    else if (cmd.e_link)     e <= link_q;
    if (cmd.pop_take) pend_node <= 7'(NCW'(stack_q) + NCW'(1));
    // a popped node is held until the next pop or the end tells whether it is last
    if (cmd.pop && pend_valid) begin
      node          <= pend_node;
      node_valid    <= 1'b1;
      last          <= 1'b0;
      complete      <= 1'b0;
      edges_dropped <= drop_flag;
    end else if (cmd.finish) begin
      node          <= pend_valid ? pend_node : 7'd0;
      node_valid    <= pend_valid;
      last          <= 1'b1;
      complete      <= (emitted == n_act);
      edges_dropped <= drop_flag;
    end
  end

  `TSI_ASSERT(a_push_room, clk, rst, push |-> (int'(depth) < MAX_NODES))
  `TSI_ASSERT(a_add_room, clk, rst, cmd.add_wr |-> (int'(edge_count) < MAX_EDGES))
  `TSI_ASSERT(a_pop_nonempty, clk, rst, cmd.pop |-> (depth != '0))
  `TSI_ASSERT_NORST(a_last_single, clk, (result_strobe && last) |=> !result_strobe)

endmodule

// ===== hdl/topological_sort_indegree.sv =====
// Top level of the topological sort block: controller plus datapath.
//
// Items are taken when start is high and busy is low; kind selects add edge,
// run sort or clear graph. An add edge is checked and its list head read in
// idle; a valid edge is then written along with its new head. In a run every
// memory has one read port with a registered output, and each edge visit into
// an active node is a read-modify-write of the in-degree store. Results come
// out on their ports for one cycle with result_strobe and cannot be stalled,
// and the last one is marked by last. After reset and after each clear item
// the list-head store is swept to empty, one entry per cycle, with busy high.
// The num_nodes register is always ready for writes but must only be written
// while the block is idle.
module topological_sort_indegree #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] kind,
  input  logic [6:0] from_node,
  input  logic [6:0] to_node,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data,
  output logic       result_strobe,
  output logic [6:0] node,
  output logic       node_valid,
  output logic       last,
  output logic       complete,
  output logic       edges_dropped
);

  tsi_pkg::cmd_t  cmd;
  tsi_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  tsi_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  tsi_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .from_node     (from_node),
    .to_node       (to_node),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .node          (node),
    .node_valid    (node_valid),
    .last          (last),
    .complete      (complete),
    .edges_dropped (edges_dropped)
  );

endmodule

// ===== test/tb_topological_sort_indegree.sv =====
`timescale 1ns / 1ps
// Testbench for the topological sort block: graph model, directed and random items, result checks.
module tb_topological_sort_indegree;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;
  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam logic [8:0] NO_EDGE = 9'(MAX_EDGES);
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 50;

  typedef struct {
    logic [6:0] node;
    logic       node_valid;
    logic       last;
    logic       complete;
    logic       edges_dropped;
  } sort_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] kind = tsi_pkg::KIND_ADD;
  logic [6:0] from_node = '0;
  logic [6:0] to_node = '0;
  logic       cfg_valid = 1'b0;
  logic [6:0] cfg_data = '0;
  logic       busy;
  logic       cfg_ready;
  logic       result_strobe;
  logic [6:0] node;
  logic       node_valid;
  logic       last;
  logic       complete;
  logic       edges_dropped;

  // graph model
  logic [8:0]  first_edge [MAX_NODES];
  logic [5:0]  edge_dst [MAX_EDGES];
  logic [8:0]  next_edge [MAX_EDGES];
  int          stored_edges;
  logic        drop_seen;
  logic [6:0]  node_limit;

  sort_out_t   sort_expect [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          sender_idle_pct = 0;

  topological_sort_indegree #(
    .MAX_NODES(MAX_NODES),
    .MAX_EDGES(MAX_EDGES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .from_node(from_node),
    .to_node(to_node),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .result_strobe(result_strobe),
    .node(node),
    .node_valid(node_valid),
    .last(last),
    .complete(complete),
    .edges_dropped(edges_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int active_count();
    return (node_limit > MAX_NODES) ? MAX_NODES : int'(node_limit);
  endfunction

  function automatic void model_clear();
    foreach (first_edge[i]) first_edge[i] = NO_EDGE;
    stored_edges = 0;
    drop_seen = 1'b0;
  endfunction

  function automatic void model_add(input logic [6:0] src, input logic [6:0] dst);
    int n;
    n = active_count();
    if (src == 0 || src > n || dst == 0 || dst > n || stored_edges >= MAX_EDGES) begin
      drop_seen = 1'b1;
    end else begin
      edge_dst[stored_edges] = 6'(dst - 1);
      next_edge[stored_edges] = first_edge[src - 1];
      first_edge[src - 1] = 9'(stored_edges);
      stored_edges++;
    end
  endfunction

  // Kahn's sort with a LIFO of ready nodes; one result per popped node, else one empty result
  function automatic void model_sort();
    int n;
    int u;
    int t;
    int e;
    int depth;
    int emitted;
    int indeg [MAX_NODES];
    int ready [MAX_NODES];
    sort_out_t r;
    n = active_count();
    depth = 0;
    emitted = 0;
    foreach (indeg[i]) indeg[i] = 0;
    for (u = 0; u < n; u++) begin
      for (e = int'(first_edge[u]); e < stored_edges; e = int'(next_edge[e])) begin
        t = int'(edge_dst[e]);
        if (t < n) indeg[t]++;
      end
    end
    for (u = 0; u < n; u++) begin
      if (indeg[u] == 0) begin
        ready[depth] = u;
        depth++;
      end
    end
    r.edges_dropped = drop_seen;
    r.last = 1'b0;
    r.complete = 1'b0;
    r.node_valid = 1'b1;
    while (depth > 0 && emitted < MAX_NODES) begin
      depth--;
      u = ready[depth];
      r.node = 7'(u + 1);
      sort_expect.push_back(r);
      emitted++;
      for (e = int'(first_edge[u]); e < stored_edges; e = int'(next_edge[e])) begin
        t = int'(edge_dst[e]);
        if (t < n && indeg[t] != 0) begin
          indeg[t]--;
          if (indeg[t] == 0) begin
            ready[depth] = t;
            depth++;
          end
        end
      end
    end
    if (emitted == 0) begin
      r.node = '0;
      r.node_valid = 1'b0;
      r.complete = (n == 0);
    end else begin
      r = sort_expect.pop_back();
      r.complete = (emitted == n);
    end
    r.last = 1'b1;
    sort_expect.push_back(r);
  endfunction

  function automatic void model_item(input logic [1:0] k, input logic [6:0] src,
                                     input logic [6:0] dst);
    case (k)
      tsi_pkg::KIND_ADD:   model_add(src, dst);
      tsi_pkg::KIND_RUN:   model_sort();
      tsi_pkg::KIND_CLEAR: model_clear();
      default:             ;
    endcase
  endfunction

  always @(posedge clk) begin : check_results
    sort_out_t want;
    if (!rst && result_strobe) begin
      if (sort_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: node %0d valid %0b last %0b complete %0b dropped %0b",
                   node, node_valid, last, complete, edges_dropped);
      end else begin
        want = sort_expect.pop_front();
        if (want.node !== node || want.node_valid !== node_valid || want.last !== last ||
            want.complete !== complete || want.edges_dropped !== edges_dropped) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected node %0d valid %0b last %0b complete %0b dropped %0b",
                     want.node, want.node_valid, want.last, want.complete,
                     want.edges_dropped);
            $display("                 got node %0d valid %0b last %0b complete %0b dropped %0b",
                     node, node_valid, last, complete, edges_dropped);
          end
        end
      end
    end
  end

  // start stays high from one accepted item into the next unless the sender idles
  task automatic send_item(input logic [1:0] k, input logic [6:0] src, input logic [6:0] dst);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    from_node <= src;
    to_node <= dst;
    @(posedge clk);
    while (busy) @(posedge clk);
    model_item(k, src, dst);
  endtask

  task automatic stop_sending();
    start <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (sort_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_num_nodes(input logic [6:0] value);
    stop_sending();
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    node_limit = value;
  endtask

  task automatic test_directed_cases();
    sender_idle_pct = 12;
    // empty graph at the reset size: all 64 nodes, highest first
    send_item(tsi_pkg::KIND_RUN, '0, '0);
    // bad endpoints set the drop flag
    send_item(tsi_pkg::KIND_ADD, 7'd0, 7'd5);
    send_item(tsi_pkg::KIND_ADD, 7'd127, 7'd127);
    send_item(tsi_pkg::KIND_ADD, 7'd65, 7'd1);
    send_item(tsi_pkg::KIND_ADD, 7'd64, 7'd1);
    send_item(tsi_pkg::KIND_RUN, 7'd127, 7'd127);
    send_item(KIND_NOP, 7'd127, 7'd127);
    send_item(tsi_pkg::KIND_CLEAR, 7'd127, 7'd127);
    send_item(tsi_pkg::KIND_RUN, '0, '0);
    // no nodes at all
    write_num_nodes(7'd0);
    send_item(tsi_pkg::KIND_RUN, '0, '0);
    // oversized register acts as the full node range
    write_num_nodes(7'd127);
    send_item(tsi_pkg::KIND_ADD, 7'd1, 7'd64);
    send_item(tsi_pkg::KIND_RUN, '0, '0);
    // pure cycle: nothing can be emitted
    write_num_nodes(7'd3);
    send_item(tsi_pkg::KIND_CLEAR, '0, '0);
    send_item(tsi_pkg::KIND_ADD, 7'd1, 7'd2);
    send_item(tsi_pkg::KIND_ADD, 7'd2, 7'd3);
    send_item(tsi_pkg::KIND_ADD, 7'd3, 7'd1);
    send_item(tsi_pkg::KIND_RUN, '0, '0);
    // edges into nodes above a shrunk range are ignored at the run
    write_num_nodes(7'd8);
    send_item(tsi_pkg::KIND_CLEAR, '0, '0);
    send_item(tsi_pkg::KIND_ADD, 7'd2, 7'd8);
    send_item(tsi_pkg::KIND_ADD, 7'd8, 7'd3);
    send_item(tsi_pkg::KIND_ADD, 7'd1, 7'd2);
    write_num_nodes(7'd4);
    send_item(tsi_pkg::KIND_RUN, '0, '0);
    // single node with a self loop
    write_num_nodes(7'd1);
    send_item(tsi_pkg::KIND_ADD, 7'd1, 7'd1);
    send_item(tsi_pkg::KIND_ADD, 7'd1, 7'd2);
    send_item(tsi_pkg::KIND_RUN, '0, '0);
  endtask

  task automatic test_edge_store_full();
    int a;
    sender_idle_pct = 12;
    write_num_nodes(7'd64);
    send_item(tsi_pkg::KIND_CLEAR, '0, '0);
    for (int i = 0; i < MAX_EDGES + 3; i++) begin
      a = $urandom_range(1, MAX_NODES - 1);
      send_item(tsi_pkg::KIND_ADD, 7'(a), 7'($urandom_range(a + 1, MAX_NODES)));
    end
    send_item(tsi_pkg::KIND_RUN, '0, '0);
    send_item(tsi_pkg::KIND_CLEAR, '0, '0);
  endtask

  task automatic test_random_graphs(input int idle_pct, input int item_budget);
    int sent;
    int n;
    int act;
    int count;
    int a;
    int pick;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < item_budget) begin
      pick = $urandom_range(99);
      if (pick < 75) n = $urandom_range(1, 12);
      else if (pick < 90) n = $urandom_range(13, 64);
      else if (pick < 95) n = 0;
      else n = $urandom_range(64, 127);
      write_num_nodes(7'(n));
      act = (n > MAX_NODES) ? MAX_NODES : n;
      if ($urandom_range(99) < 80) begin
        send_item(tsi_pkg::KIND_CLEAR, 7'($urandom), 7'($urandom));
        sent++;
      end
      count = $urandom_range(0, 14);
      for (int i = 0; i < count; i++) begin
        pick = $urandom_range(99);
        if (pick < 75 && act >= 2) begin
          // forward edges keep the graph acyclic
          a = $urandom_range(1, act - 1);
          send_item(tsi_pkg::KIND_ADD, 7'(a), 7'($urandom_range(a + 1, act)));
          sent++;
        end else if (pick < 85 && act >= 1) begin
          send_item(tsi_pkg::KIND_ADD, 7'($urandom_range(1, act)),
                    7'($urandom_range(1, act)));
          sent++;
        end else if (pick < 95) begin
          send_item(tsi_pkg::KIND_ADD, 7'($urandom), 7'($urandom));
          sent++;
        end else begin
          send_item(KIND_NOP, 7'($urandom), 7'($urandom));
        end
      end
      send_item(tsi_pkg::KIND_RUN, 7'($urandom), 7'($urandom));
      sent++;
      if ($urandom_range(99) < 25 && act > 1) begin
        write_num_nodes(7'($urandom_range(1, act - 1)));
        send_item(tsi_pkg::KIND_RUN, 7'($urandom), 7'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    node_limit = 7'(MAX_NODES);
    model_clear();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_edge_store_full();
    test_random_graphs(12, 60);
    test_random_graphs(68, 60);
    test_random_graphs(0, 60);
    stop_sending();
    while (sort_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && sort_expect.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
